### rtl/tpfm_pkg.sv
// Shared types and constants for the tooth period fault monitor.
`default_nettype none

package tpfm_pkg;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 208;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned TOOTH_W   = 8;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [PERIOD_W-1:0] JITTER_LIMIT_RST = 16'd500;
  localparam logic [PERIOD_W-1:0] NOISE_LIMIT_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0] LOWEST_RST       = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TOOTH = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_NOISE  = 2'd1,
    ERR_JITTER = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JITTER_LIMIT = 2'd0,
    CFG_NOISE_LIMIT  = 2'd1,
    CFG_LOG_ENABLE   = 2'd2
  } cfg_idx_e;

  // One log ring entry.
  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [1:0]          error;
    logic [TOOTH_W-1:0]  tooth;
    logic [PERIOD_W-1:0] period;
    logic [STAMP_W-1:0]  stamp;
  } tpfm_entry_t;

endpackage

`default_nettype wire

### rtl/tooth_period_fault_monitor.sv
// Top level of the tooth period fault monitor.
`default_nettype none

// Tooth period fault monitor. Each slave transfer carries one operation in
// tuser: a tooth event, a clear of the error counters, or a read of one log
// entry. Every operation yields exactly one master transfer with the
// counters and period extremes as they stand after it. A new transfer is
// taken every clock unless the master side stalls; a result passes through
// the input stage holding the item and the log read data, then the output
// register, and waits there while the master side stalls. The log is a
// LOG_DEPTH-entry ring memory with one write and one read port; it reads as
// zero until written, which a fill count tracks, so no clearing pass is
// needed after reset. Configuration writes are always taken and must only
// be issued while no item is in flight.
module tooth_period_fault_monitor
  import tpfm_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // slave stream
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] period, [23:16] tooth_number, [39:24] speed_rpm,
  // [71:40] stamp, [77:72] log_slot, [79:78] zero
  input  wire  [S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] op
  input  wire  [1:0]               s_axis_tuser,
  // master stream
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  // [1:0] error_code, [33:2] noise_count, [65:34] jitter_count,
  // [97:66] error_total, [113:98] min_seen, [129:114] max_seen,
  // [161:130] entry_time, [177:162] entry_period, [185:178] entry_tooth,
  // [187:186] entry_error, [203:188] entry_speed, [207:204] zero
  output logic [M_TDATA_W-1:0]     m_axis_tdata,
  // configuration write channel
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);      // ring address
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);  // fill count
  localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [AW-1:0] LAST_PTR = AW'(LOG_DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(LOG_DEPTH);

  // configuration
  logic [PERIOD_W-1:0] jit_lim_q, noise_lim_q;
  logic                log_en_q;

  // monitor state
  logic [PERIOD_W-1:0] low_q, low_d, high_q, high_d, ref_q, ref_d;
  logic [CNT_W-1:0]    noise_q, noise_d, jit_q, jit_d, tot_q, tot_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       fill_q, fill_d;

  // input stage
  logic                s1_v_q;
  logic [1:0]          s1_op_q;
  logic [PERIOD_W-1:0] s1_period_q;
  logic [TOOTH_W-1:0]  s1_tooth_q;
  logic [SPEED_W-1:0]  s1_speed_q;
  logic [STAMP_W-1:0]  s1_stamp_q;
  logic [SLOT_W-1:0]   s1_slot_q;
  tpfm_entry_t         rd_q;

  // output register
  logic                  out_v_q;
  logic [M_TDATA_W-1:0]  out_q, out_d;

  // ring memory
  tpfm_entry_t ring_mem [LOG_DEPTH];
  tpfm_entry_t ring_wd;
  logic        ring_we;
  logic [AW-1:0] ring_ra;
  logic [SW-1:0] in_slot_ext, s1_slot_ext;

  logic s1_go, in_xfer;
  logic [1:0]          code;
  logic [PERIOD_W-1:0] diff;
  tpfm_entry_t         entry;

  // handshakes: stage advances when the output register is free or drains
  assign s1_go         = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_go;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  assign in_slot_ext = SW'(s_axis_tdata[77:72]);
  assign s1_slot_ext = SW'(s1_slot_q);
  assign ring_ra     = in_slot_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jit_lim_q   <= JITTER_LIMIT_RST;
      noise_lim_q <= NOISE_LIMIT_RST;
      log_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_JITTER_LIMIT: jit_lim_q   <= cfg_data_i;
        CFG_NOISE_LIMIT:  noise_lim_q <= cfg_data_i;
        CFG_LOG_ENABLE:   log_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Ring write from the stage; the read for an incoming item bypasses a
  // write to the same entry in the same cycle.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ptr_q] <= ring_wd;
    end
    if (in_xfer) begin
      rd_q <= (ring_we && (ptr_q == ring_ra)) ? ring_wd : ring_mem[ring_ra];
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= s_axis_tuser;
      s1_period_q <= s_axis_tdata[15:0];
      s1_tooth_q  <= s_axis_tdata[23:16];
      s1_speed_q  <= s_axis_tdata[39:24];
      s1_stamp_q  <= s_axis_tdata[71:40];
      s1_slot_q   <= s_axis_tdata[77:72];
    end
  end

  // Per-item work: extremes, noise and jitter checks, counters, log write.
  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    ref_d   = ref_q;
    noise_d = noise_q;
    jit_d   = jit_q;
    tot_d   = tot_q;
    ptr_d   = ptr_q;
    fill_d  = fill_q;
    code    = ERR_NONE;
    ring_we = 1'b0;
    entry   = '0;
    diff    = (s1_period_q > ref_q) ? (s1_period_q - ref_q) : (ref_q - s1_period_q);

    unique case (s1_op_q)
      OP_TOOTH: begin
        if (s1_period_q < low_q)  low_d  = s1_period_q;
        if (s1_period_q > high_q) high_d = s1_period_q;
        if (s1_period_q < noise_lim_q) begin
          code    = ERR_NOISE;
          noise_d = noise_q + CNT_W'(1);
          tot_d   = tot_q + CNT_W'(1);
        end else if ((ref_q != '0) && (diff > jit_lim_q)) begin
          code  = ERR_JITTER;
          jit_d = jit_q + CNT_W'(1);
          tot_d = tot_q + CNT_W'(1);
        end
        if (code == ERR_NONE) ref_d = s1_period_q;
        if (log_en_q) begin
          ring_we = s1_go;
          ptr_d   = (ptr_q == LAST_PTR) ? '0 : ptr_q + AW'(1);
          if (fill_q != FULL) fill_d = fill_q + CW'(1);
        end
      end
      OP_CLEAR: begin
        noise_d = '0;
        jit_d   = '0;
        tot_d   = '0;
      end
      OP_READ: begin
        // entries at or past the fill count were never written: zero
        if (s1_slot_ext < SW'(fill_q)) entry = rd_q;
      end
      default: ;
    endcase

    ring_wd = '{speed: s1_speed_q, error: code, tooth: s1_tooth_q,
                period: s1_period_q, stamp: s1_stamp_q};

    out_d = {4'd0, entry.speed, entry.error, entry.tooth, entry.period,
             entry.stamp, high_d, low_d, tot_d, jit_d, noise_d, code};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      low_q   <= LOWEST_RST;
      high_q  <= '0;
      ref_q   <= '0;
      noise_q <= '0;
      jit_q   <= '0;
      tot_q   <= '0;
      ptr_q   <= '0;
      fill_q  <= '0;
    end else begin
      if (s_axis_tready) s1_v_q <= s_axis_tvalid;
      if (s1_go) begin
        out_v_q <= 1'b1;
        low_q   <= low_d;
        high_q  <= high_d;
        ref_q   <= ref_d;
        noise_q <= noise_d;
        jit_q   <= jit_d;
        tot_q   <= tot_d;
        ptr_q   <= ptr_d;
        fill_q  <= fill_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) out_q <= out_d;
  end

endmodule

`default_nettype wire

### rtl/tpfm_checker.sv
// Port-level checker for the tooth period fault monitor, with its bind.
`default_nettype none

module tpfm_checker
  import tpfm_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [M_TDATA_W-1:0]  m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // total always equals noise plus jitter, modulo wrap
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[97:66] == 32'(m_axis_tdata[33:2] + m_axis_tdata[65:34]))
    else $error("error total disagrees with noise and jitter counts");

  // once a period below all-ones was seen, min cannot exceed max
  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[113:98] != 16'hFFFF) |->
      m_axis_tdata[113:98] <= m_axis_tdata[129:114])
    else $error("min period above max period");

  // a flagged tooth event carries no log entry
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ERR_NONE) |->
      m_axis_tdata[203:130] == '0)
    else $error("entry fields set on a tooth event");

endmodule

bind tooth_period_fault_monitor tpfm_checker u_tpfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tooth_period_checker.sv
// Checker for the tooth period fault monitor: predicts each result and compares it.
`timescale 1ns / 100ps

module tooth_period_checker
  import tpfm_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_tvalid_i,
  input  wire                   s_tready_i,
  input  wire  [S_TDATA_W-1:0]  s_tdata_i,
  input  wire  [1:0]            s_tuser_i,
  input  wire                   m_tvalid_i,
  input  wire                   m_tready_i,
  input  wire  [M_TDATA_W-1:0]  m_tdata_i,
  input  wire                   cfg_valid_i,
  input  wire                   cfg_ready_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DAT_W-1:0]  cfg_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o
);

  localparam int unsigned RING_DEPTH = 64;

  // slave tdata, lowest field last
  typedef struct packed {
    logic [1:0]          pad;
    logic [SLOT_W-1:0]   slot;
    logic [STAMP_W-1:0]  stamp;
    logic [SPEED_W-1:0]  speed;
    logic [TOOTH_W-1:0]  tooth;
    logic [PERIOD_W-1:0] period;
  } tooth_item_t;

  // master tdata, lowest field last
  typedef struct packed {
    logic [3:0]          pad;
    logic [SPEED_W-1:0]  entry_speed;
    logic [1:0]          entry_error;
    logic [TOOTH_W-1:0]  entry_tooth;
    logic [PERIOD_W-1:0] entry_period;
    logic [STAMP_W-1:0]  entry_time;
    logic [PERIOD_W-1:0] max_seen;
    logic [PERIOD_W-1:0] min_seen;
    logic [CNT_W-1:0]    error_total;
    logic [CNT_W-1:0]    jitter_count;
    logic [CNT_W-1:0]    noise_count;
    logic [1:0]          error_code;
  } status_report_t;

  logic [CFG_DAT_W-1:0] jitter_limit;
  logic [CFG_DAT_W-1:0] noise_limit;
  logic                 log_on;

  logic [PERIOD_W-1:0]  lowest;
  logic [PERIOD_W-1:0]  highest;
  logic [PERIOD_W-1:0]  reference;
  logic [CNT_W-1:0]     noise_cnt;
  logic [CNT_W-1:0]     jitter_cnt;
  logic [CNT_W-1:0]     all_errors;
  logic [SLOT_W-1:0]    ring_wr;
  tpfm_entry_t          ring [RING_DEPTH];

  status_report_t       awaited_reports [$];

  task automatic apply_operation(input logic [1:0] op, input tooth_item_t item,
                                 output status_report_t rep);
    logic [PERIOD_W-1:0] delta;
    logic [1:0]          code;
    rep  = '0;
    code = ERR_NONE;
    case (op)
      OP_TOOTH: begin
        if (item.period < lowest) lowest = item.period;
        if (item.period > highest) highest = item.period;
        if (item.period < noise_limit) begin
          code       = ERR_NOISE;
          noise_cnt  = noise_cnt + CNT_W'(1);
          all_errors = all_errors + CNT_W'(1);
        end else if (reference != '0) begin
          delta = (item.period > reference) ? item.period - reference
                                            : reference - item.period;
          if (delta > jitter_limit) begin
            code       = ERR_JITTER;
            jitter_cnt = jitter_cnt + CNT_W'(1);
            all_errors = all_errors + CNT_W'(1);
          end
        end
        if (log_on) begin
          ring[ring_wr] = '{speed: item.speed, error: code, tooth: item.tooth,
                            period: item.period, stamp: item.stamp};
          ring_wr = ring_wr + SLOT_W'(1);   // wraps with the slot width
        end
        // only a clean period moves the reference
        if (code == ERR_NONE) reference = item.period;
      end
      OP_CLEAR: begin
        noise_cnt  = '0;
        jitter_cnt = '0;
        all_errors = '0;
      end
      OP_READ: begin
        rep.entry_time   = ring[item.slot].stamp;
        rep.entry_period = ring[item.slot].period;
        rep.entry_tooth  = ring[item.slot].tooth;
        rep.entry_error  = ring[item.slot].error;
        rep.entry_speed  = ring[item.slot].speed;
      end
      default: ;
    endcase
    rep.error_code   = code;
    rep.noise_count  = noise_cnt;
    rep.jitter_count = jitter_cnt;
    rep.error_total  = all_errors;
    rep.min_seen     = lowest;
    rep.max_seen     = highest;
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches_o = mismatches_o + 1;
    end
  endtask

  task automatic compare_report(input status_report_t want, input status_report_t got);
    check_field("error_code",   CNT_W'(want.error_code),   CNT_W'(got.error_code));
    check_field("noise_count",  want.noise_count,          got.noise_count);
    check_field("jitter_count", want.jitter_count,         got.jitter_count);
    check_field("error_total",  want.error_total,          got.error_total);
    check_field("min_seen",     CNT_W'(want.min_seen),     CNT_W'(got.min_seen));
    check_field("max_seen",     CNT_W'(want.max_seen),     CNT_W'(got.max_seen));
    check_field("entry_time",   want.entry_time,           got.entry_time);
    check_field("entry_period", CNT_W'(want.entry_period), CNT_W'(got.entry_period));
    check_field("entry_tooth",  CNT_W'(want.entry_tooth),  CNT_W'(got.entry_tooth));
    check_field("entry_error",  CNT_W'(want.entry_error),  CNT_W'(got.entry_error));
    check_field("entry_speed",  CNT_W'(want.entry_speed),  CNT_W'(got.entry_speed));
    check_field("tdata padding", CNT_W'(want.pad),         CNT_W'(got.pad));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    status_report_t rep;
    if (!rst_ni) begin
      mismatches_o  = 0;
      jitter_limit  = JITTER_LIMIT_RST;
      noise_limit   = NOISE_LIMIT_RST;
      log_on        = 1'b0;
      lowest        = LOWEST_RST;
      highest       = '0;
      reference     = '0;
      noise_cnt     = '0;
      jitter_cnt    = '0;
      all_errors    = '0;
      ring_wr       = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      awaited_reports.delete();
    end else begin
      // results first, so a spurious one is never matched to this edge's item
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_tdata_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          compare_report(awaited_reports.pop_front(), status_report_t'(m_tdata_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_JITTER_LIMIT: jitter_limit = cfg_data_i;
          CFG_NOISE_LIMIT:  noise_limit  = cfg_data_i;
          CFG_LOG_ENABLE:   log_on       = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_operation(s_tuser_i, tooth_item_t'(s_tdata_i), rep);
        awaited_reports.push_back(rep);
      end
    end
    pending_o = awaited_reports.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the tooth period fault monitor: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb;
  import tpfm_pkg::*;

  // op code the block leaves unused; it must pass through with no effect
  localparam logic [1:0]  OP_SPARE   = 2'd3;
  // cycles with no transfer on any channel before the run is abandoned
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_ITEMS = 62;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          quiet_cycles;

  // stimulus state: a drifting wheel period, a running timestamp and tooth index
  int                   nominal_period;
  logic [STAMP_W-1:0]   stamp_acc;
  logic [TOOTH_W-1:0]   tooth_idx;
  // remaining length of a stretch with no idling, per side
  int unsigned          tx_calm;
  int unsigned          rx_calm;

  tooth_period_fault_monitor i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  tooth_period_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("tooth_period_fault_monitor test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle length for either side: mostly none or short, now and then long, and
  // occasionally a stretch of back-to-back transfers with no idling at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Drive one item from a falling edge, hold it until the transfer, then idle.
  // Leaves tvalid high when no gap follows, so the next item goes back to back.
  task automatic send_item(input logic [1:0] op, input logic [PERIOD_W-1:0] period,
                           input logic [TOOTH_W-1:0] tooth, input logic [SPEED_W-1:0] speed,
                           input logic [STAMP_W-1:0] stamp, input logic [SLOT_W-1:0] slot);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, slot, stamp, speed, tooth, period};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Register writes only go in once the block has drained.
  task automatic reconfigure(input logic [CFG_DAT_W-1:0] jitter, input logic [CFG_DAT_W-1:0] noise,
                             input logic log_on);
    settle();
    write_reg(CFG_JITTER_LIMIT, jitter);
    write_reg(CFG_NOISE_LIMIT, noise);
    write_reg(CFG_LOG_ENABLE, {{(CFG_DAT_W-1){1'b0}}, log_on});
    cfg_valid_i <= 1'b0;
  endtask

  // Random item. Most are tooth events, and most periods lie close to a slowly
  // drifting period so the good/jitter boundary is crossed often; the rest are
  // noise-length periods, extremes and fully random values.
  task automatic send_random_item();
    int unsigned        r;
    int                 p;
    logic [1:0]         op;
    r = $urandom_range(0, 99);
    if (r < 74)      op = OP_TOOTH;
    else if (r < 79) op = OP_CLEAR;
    else if (r < 94) op = OP_READ;
    else             op = OP_SPARE;

    nominal_period = nominal_period + int'($urandom_range(0, 40)) - 20;
    if ($urandom_range(0, 49) == 0) nominal_period = int'($urandom_range(200, 60000));
    if (nominal_period < 200)   nominal_period = 200;
    if (nominal_period > 60000) nominal_period = 60000;

    r = $urandom_range(0, 99);
    if (r < 60)      p = nominal_period + int'($urandom_range(0, 1200)) - 600;
    else if (r < 70) p = int'($urandom_range(0, 200));
    else if (r < 80) p = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    else             p = int'($urandom_range(0, 65535));
    if (p < 0)     p = 0;
    if (p > 65535) p = 65535;

    tooth_idx = ($urandom_range(0, 19) == 0) ? TOOTH_W'($urandom_range(0, 255))
                                              : tooth_idx + TOOTH_W'(1);
    stamp_acc = ($urandom_range(0, 19) == 0) ? $urandom() : stamp_acc + STAMP_W'(p);

    send_item(op, PERIOD_W'(p), tooth_idx, SPEED_W'($urandom_range(0, 65535)), stamp_acc,
              SLOT_W'($urandom_range(0, 63)));
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_jitter_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 80) return CFG_DAT_W'($urandom_range(0, 1500));
    return CFG_DAT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_noise_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 85) return CFG_DAT_W'($urandom_range(0, 400));
    return CFG_DAT_W'($urandom_range(0, 65535));
  endfunction

  // Result side: runs of ready, broken up by stalls of random length.
  initial begin
    int unsigned burst;
    int unsigned stall;
    m_axis_tready = 1'b0;
    rx_calm       = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      m_axis_tready <= 1'b1;
      repeat (burst) @(negedge clk_i);
      stall = pick_gap(rx_calm);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed cases, then random phases under varied limits.
  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_TOOTH;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_JITTER_LIMIT;
    cfg_data_i     = '0;
    nominal_period = 5000;
    stamp_acc      = '0;
    tooth_idx      = '0;
    tx_calm        = 0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset limits (jitter 500, noise 100), logging off.
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd0);           // ring is zero after reset
    send_item(OP_SPARE, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(OP_TOOTH, 16'd0, 8'd0, 16'd0, 32'd0, 6'd0);            // noise, minimum drops to 0
    send_item(OP_TOOTH, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F); // first good period
    send_item(OP_TOOTH, 16'd1000, 8'd1, 16'd1200, 32'd1000, 6'd0);   // far from reference: jitter
    send_item(OP_CLEAR, 16'd0, 8'd0, 16'd0, 32'd0, 6'd0);
    send_item(OP_TOOTH, 16'hFFFF, 8'd2, 16'd900, 32'd2000, 6'd0);

    // Logging on. With the widest jitter limit and no noise limit a period of
    // zero is good, so the reference becomes zero; under zero limits the next
    // period is then not checked for jitter.
    reconfigure(16'hFFFF, 16'd0, 1'b1);
    send_item(OP_TOOTH, 16'd0, 8'd10, 16'hAAAA, 32'h5555_5555, 6'd0);
    reconfigure(16'd0, 16'd0, 1'b1);
    send_item(OP_TOOTH, 16'd5, 8'd11, 16'h5555, 32'hAAAA_AAAA, 6'd0);
    send_item(OP_TOOTH, 16'd5, 8'd12, 16'd3000, 32'd30, 6'd0);       // equal period stays good
    send_item(OP_TOOTH, 16'd6, 8'd13, 16'd3000, 32'd36, 6'd0);       // off by one: jitter
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd0);
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd1);
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd2);
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd3);
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'h3F);           // not yet written

    // Full-scale limits: everything but the largest period is noise.
    reconfigure(16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_TOOTH, 16'hFFFE, 8'd20, 16'd100, 32'd40, 6'd0);
    send_item(OP_TOOTH, 16'hFFFF, 8'd21, 16'd100, 32'd50, 6'd0);
    send_item(OP_READ,  16'd0, 8'd0, 16'd0, 32'd0, 6'd4);
    send_item(OP_SPARE, 16'd0, 8'd0, 16'd0, 32'd0, 6'd0);
    send_item(OP_CLEAR, 16'd0, 8'd0, 16'd0, 32'd0, 6'd0);

    // Random phases; the first three pin the extremes and the reset setting.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       reconfigure(16'd0, 16'd0, 1'b1);
        1:       reconfigure(16'hFFFF, 16'hFFFF, 1'b1);
        2:       reconfigure(JITTER_LIMIT_RST, NOISE_LIMIT_RST, 1'b0);
        default: reconfigure(pick_jitter_limit(), pick_noise_limit(),
                             $urandom_range(0, 3) != 0);
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tooth_period_fault_monitor test passed");
    end else begin
      $display("tooth_period_fault_monitor test failed");
    end
    $finish;
  end

endmodule
